// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion helper macros
// Concurrent assertion wrappers that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- rtl/core/sac_pkg.sv -----
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types, widths and the arctangent table of the angle calibration core.
// ----------------------------------------------------------------------------
`default_nettype none

package sac_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int AMP_W      = 15;
    localparam int ANGLE_W    = 17;
    localparam int VEC_W      = 60;
    localparam int Z_W        = 34;
    localparam int ATAN_W     = 30;
    localparam int TAB_IDX_W  = 5;
    localparam int FRAC_BITS  = 24;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_sample;
        logic signed [SAMPLE_W-1:0] y_sample;
    } sample_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]         angle_deg;
        logic                       angle_valid;
        logic signed [SAMPLE_W-1:0] offset_x_out;
        logic signed [SAMPLE_W-1:0] offset_y_out;
        logic [AMP_W-1:0]           amplitude_x_out;
        logic [AMP_W-1:0]           amplitude_y_out;
    } result_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] offset_x;
        logic signed [SAMPLE_W-1:0] offset_y;
        logic [AMP_W-1:0]           amp_x;
        logic [AMP_W-1:0]           amp_y;
    } window_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] xc;
        logic signed [VEC_W-1:0] yc;
    } vec_t;

    // atan(2^-i) in units of 2^-24 degree.
    function automatic logic [ATAN_W-1:0] atan_lookup(input logic [TAB_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = 30'd754974720;
            5'd1:    val = 30'd445687602;
            5'd2:    val = 30'd235489089;
            5'd3:    val = 30'd119537938;
            5'd4:    val = 30'd60000934;
            5'd5:    val = 30'd30029717;
            5'd6:    val = 30'd15018523;
            5'd7:    val = 30'd7509720;
            5'd8:    val = 30'd3754917;
            5'd9:    val = 30'd1877466;
            5'd10:   val = 30'd938734;
            5'd11:   val = 30'd469367;
            5'd12:   val = 30'd234684;
            5'd13:   val = 30'd117342;
            5'd14:   val = 30'd58671;
            5'd15:   val = 30'd29335;
            5'd16:   val = 30'd14668;
            5'd17:   val = 30'd7334;
            5'd18:   val = 30'd3667;
            5'd19:   val = 30'd1833;
            5'd20:   val = 30'd917;
            5'd21:   val = 30'd458;
            5'd22:   val = 30'd229;
            5'd23:   val = 30'd115;
            5'd24:   val = 30'd57;
            5'd25:   val = 30'd29;
            5'd26:   val = 30'd14;
            5'd27:   val = 30'd7;
            5'd28:   val = 30'd4;
            5'd29:   val = 30'd2;
            5'd30:   val = 30'd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sac_window.sv -----
// ----------------------------------------------------------------------------
// sac_window
// Tracks the min/max window of both axes and derives offsets and amplitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_window
    import sac_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    update,
    input  sample_t sample,
    output window_t win
);

    localparam int SUM_W = SAMPLE_W + 1;

    logic signed [SAMPLE_W-1:0] max_x_reg, min_x_reg, max_y_reg, min_y_reg;
    logic signed [SAMPLE_W-1:0] max_x_next, min_x_next, max_y_next, min_y_next;
    logic signed [SUM_W-1:0]    sum_x, sum_y, span_x, span_y;

    // Halving that truncates toward zero.
    function automatic logic signed [SAMPLE_W-1:0] half_trunc(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] adj;
        adj = s + $signed({{(SUM_W-1){1'b0}}, s[SUM_W-1]});
        return SAMPLE_W'(adj >>> 1);
    endfunction

    always_comb
    begin
        max_x_next = (sample.x_sample > max_x_reg) ? sample.x_sample : max_x_reg;
        min_x_next = (sample.x_sample < min_x_reg) ? sample.x_sample : min_x_reg;
        max_y_next = (sample.y_sample > max_y_reg) ? sample.y_sample : max_y_reg;
        min_y_next = (sample.y_sample < min_y_reg) ? sample.y_sample : min_y_reg;

        sum_x  = SUM_W'(max_x_reg) + SUM_W'(min_x_reg);
        sum_y  = SUM_W'(max_y_reg) + SUM_W'(min_y_reg);
        span_x = SUM_W'(max_x_reg) - SUM_W'(min_x_reg);
        span_y = SUM_W'(max_y_reg) - SUM_W'(min_y_reg);

        win.offset_x = half_trunc(sum_x);
        win.offset_y = half_trunc(sum_y);
        win.amp_x    = span_x[AMP_W:1];
        win.amp_y    = span_y[AMP_W:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= '0;
            min_x_reg <= '0;
            max_y_reg <= '0;
            min_y_reg <= '0;
        end
        else if (update)
        begin
            max_x_reg <= max_x_next;
            min_x_reg <= min_x_next;
            max_y_reg <= max_y_next;
            min_y_reg <= min_y_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sac_precalc.sv -----
// ----------------------------------------------------------------------------
// sac_precalc
// Offset correction and cross-normalization of one sample pair, one axis
// after the other, on a single shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_precalc
    import sac_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  sample_t sample,
    input  window_t win,
    output logic    done,
    output vec_t    vec
);

    localparam int MUL_W       = 32;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int G_W         = 31;
    localparam int MAG_W       = 29;
    localparam int V_W         = 31;
    localparam int Q_W         = 22;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int D_W         = 32;
    localparam int RECIP_SHIFT = 40;

    // floor(2^40 / 755): quotient estimate is exact or one low.
    localparam logic signed [MUL_W-1:0] RECIP_M    = 32'sd1456306791;
    localparam logic [V_W-1:0]          DIVISOR    = 31'd755;
    localparam logic [V_W-1:0]          ROUND_BIAS = 31'd377;
    localparam logic signed [G_W-1:0]   GX0        = 31'sd1951123;
    localparam logic signed [G_W-1:0]   GY0        = -31'sd1332128;
    localparam logic signed [MUL_W-1:0] GX1        = 32'sd17024;
    localparam logic signed [MUL_W-1:0] GY1        = 32'sd16980;

    typedef enum logic [3:0] {
        P_IDLE,
        P_GMUL,
        P_GSUM,
        P_NORM,
        P_RECIP,
        P_BACK,
        P_CORR,
        P_EMUL,
        P_FIN
    } pstate_t;

    pstate_t                     state_reg;
    logic                        axis_reg;
    logic                        done_reg;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic signed [DIFF_W-1:0]    diff_reg, diff_next;
    logic signed [G_W-1:0]       g_reg, g_next, g_mag;
    logic [V_W-1:0]              v_reg, v_next, rem;
    logic                        neg_reg, neg_next;
    logic [Q_W-1:0]              q0_reg, cmag_reg, cmag_next;
    logic signed [D_W-1:0]       d_reg;
    logic signed [VEC_W-1:0]     xc_reg, yc_reg, base, e_term, vec_next;
    logic signed [SAMPLE_W-1:0]  axis_off, axis_smp;
    logic [AMP_W-1:0]            other_amp;
    logic signed [MUL_W-1:0]     mul_a, mul_b;

    always_comb
    begin
        axis_off  = axis_reg ? win.offset_y : win.offset_x;
        axis_smp  = axis_reg ? sample.y_sample : sample.x_sample;
        // Each axis is scaled by the amplitude of the other one.
        other_amp = axis_reg ? win.amp_x : win.amp_y;

        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            P_GMUL:
            begin
                mul_a = MUL_W'(axis_off);
                mul_b = axis_reg ? GY1 : GX1;
            end
            P_RECIP:
            begin
                mul_a = MUL_W'(v_reg);
                mul_b = RECIP_M;
            end
            P_BACK:
            begin
                mul_a = MUL_W'(prod_reg[RECIP_SHIFT +: Q_W]);
                mul_b = MUL_W'(DIVISOR);
            end
            P_CORR:
            begin
                mul_a = MUL_W'(diff_reg);
                mul_b = MUL_W'(other_amp);
            end
            P_EMUL:
            begin
                mul_a = MUL_W'(cmag_reg);
                mul_b = MUL_W'(other_amp);
            end
            P_IDLE, P_GSUM, P_NORM, P_FIN:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;

        diff_next = DIFF_W'(axis_smp) - DIFF_W'(axis_off);
        g_next    = (axis_reg ? GY0 : GX0) + $signed(prod_reg[G_W-1:0]);

        // The correction is -(4g)/755 rounded; its magnitude is
        // floor((4|g| + 377) / 755) and it is negative when g is positive.
        g_mag    = g_reg[G_W-1] ? -g_reg : g_reg;
        v_next   = {g_mag[MAG_W-1:0], 2'b00} + ROUND_BIAS;
        neg_next = !g_reg[G_W-1] && (g_reg != '0);

        rem       = v_reg - prod_reg[V_W-1:0];
        cmag_next = q0_reg + Q_W'(rem >= DIVISOR);

        base     = VEC_W'(d_reg) <<< FRAC_BITS;
        e_term   = VEC_W'(prod_reg);
        vec_next = neg_reg ? (base + e_term) : (base - e_term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            axis_reg  <= 1'b0;
            done_reg  <= 1'b0;
            prod_reg  <= '0;
            diff_reg  <= '0;
            g_reg     <= '0;
            v_reg     <= '0;
            neg_reg   <= 1'b0;
            q0_reg    <= '0;
            cmag_reg  <= '0;
            d_reg     <= '0;
            xc_reg    <= '0;
            yc_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            prod_reg <= prod_next;
            unique case (state_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        axis_reg  <= 1'b0;
                        state_reg <= P_GMUL;
                    end
                end
                P_GMUL:
                begin
                    diff_reg  <= diff_next;
                    state_reg <= P_GSUM;
                end
                P_GSUM:
                begin
                    g_reg     <= g_next;
                    state_reg <= P_NORM;
                end
                P_NORM:
                begin
                    v_reg     <= v_next;
                    neg_reg   <= neg_next;
                    state_reg <= P_RECIP;
                end
                P_RECIP:
                begin
                    state_reg <= P_BACK;
                end
                P_BACK:
                begin
                    q0_reg    <= prod_reg[RECIP_SHIFT +: Q_W];
                    state_reg <= P_CORR;
                end
                P_CORR:
                begin
                    cmag_reg  <= cmag_next;
                    state_reg <= P_EMUL;
                end
                P_EMUL:
                begin
                    d_reg     <= prod_reg[D_W-1:0];
                    state_reg <= P_FIN;
                end
                P_FIN:
                begin
                    if (axis_reg)
                    begin
                        yc_reg    <= vec_next;
                        done_reg  <= 1'b1;
                        state_reg <= P_IDLE;
                    end
                    else
                    begin
                        xc_reg    <= vec_next;
                        axis_reg  <= 1'b1;
                        state_reg <= P_GMUL;
                    end
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign vec.xc = xc_reg;
    assign vec.yc = yc_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sac_cordic.sv -----
// ----------------------------------------------------------------------------
// sac_cordic
// Iterative vectoring CORDIC: normalize, quadrant pre-rotation, one
// micro-rotation per cycle on a shared shift/add unit, then rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_cordic
    import sac_pkg::*;
#(
    parameter int CORDIC_STEPS        = 24,
    parameter int ANGLE_FRACTION_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  vec_t               vec,
    output logic               done,
    output logic [ANGLE_W-1:0] angle
);

    localparam int STEP_W     = $clog2(CORDIC_STEPS);
    localparam int LAST_STEP  = CORDIC_STEPS - 1;
    localparam int RND_SHIFT  = FRAC_BITS - ANGLE_FRACTION_BITS;
    localparam int NORM_BIT   = 53;
    localparam int MID_BIT    = 49;
    localparam int COARSE_BIT = 37;

    localparam logic signed [Z_W-1:0] RND_HALF  = Z_W'(64'sd1 <<< (RND_SHIFT - 1));
    localparam logic signed [Z_W-1:0] FULL_TURN = Z_W'(64'sd360 <<< ANGLE_FRACTION_BITS);
    localparam logic signed [Z_W-1:0] DEG90     = Z_W'(64'sd90 <<< FRAC_BITS);

    typedef enum logic [2:0] {
        C_IDLE,
        C_NORM,
        C_ROT,
        C_ITER,
        C_ROUND
    } cstate_t;

    cstate_t                 state_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    done_reg;
    logic [ANGLE_W-1:0]      angle_reg, angle_next;
    logic signed [VEC_W-1:0] x_reg, y_reg, ax, ay, xs, ys;
    logic signed [Z_W-1:0]   z_reg, at, zr, q, qf;
    logic                    below_norm, below_mid, below_coarse;

    always_comb
    begin
        ax = x_reg[VEC_W-1] ? -x_reg : x_reg;
        ay = y_reg[VEC_W-1] ? -y_reg : y_reg;
        below_norm   = (ax[VEC_W-1:NORM_BIT] == '0) && (ay[VEC_W-1:NORM_BIT] == '0);
        below_mid    = (ax[VEC_W-1:MID_BIT] == '0) && (ay[VEC_W-1:MID_BIT] == '0);
        below_coarse = (ax[VEC_W-1:COARSE_BIT] == '0) && (ay[VEC_W-1:COARSE_BIT] == '0);

        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        at = Z_W'(atan_lookup(TAB_IDX_W'(step_reg)));

        zr = z_reg + RND_HALF;
        q  = zr >>> RND_SHIFT;
        // A non-positive angle folds up by a full turn.
        qf = (q[Z_W-1] || (q == '0)) ? (q + FULL_TURN) : q;
        angle_next = qf[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            angle_reg <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        x_reg <= vec.xc;
                        y_reg <= vec.yc;
                        z_reg <= '0;
                        // A zero vector skips the rotations; its zero angle folds up to a full turn.
                        if ((vec.xc == '0) && (vec.yc == '0))
                        begin
                            state_reg <= C_ROUND;
                        end
                        else
                        begin
                            state_reg <= C_NORM;
                        end
                    end
                end
                C_NORM:
                begin
                    // Doubling is exact, so coarse steps reach the same point.
                    if (below_coarse)
                    begin
                        x_reg <= x_reg <<< 16;
                        y_reg <= y_reg <<< 16;
                    end
                    else if (below_mid)
                    begin
                        x_reg <= x_reg <<< 4;
                        y_reg <= y_reg <<< 4;
                    end
                    else if (below_norm)
                    begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                    end
                    else
                    begin
                        state_reg <= C_ROT;
                    end
                end
                C_ROT:
                begin
                    if (x_reg[VEC_W-1])
                    begin
                        if (!y_reg[VEC_W-1])
                        begin
                            x_reg <= y_reg;
                            y_reg <= -x_reg;
                            z_reg <= DEG90;
                        end
                        else
                        begin
                            x_reg <= -y_reg;
                            y_reg <= x_reg;
                            z_reg <= -DEG90;
                        end
                    end
                    step_reg  <= '0;
                    state_reg <= C_ITER;
                end
                C_ITER:
                begin
                    if (!y_reg[VEC_W-1])
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + at;
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - at;
                    end
                    if (step_reg == STEP_W'(LAST_STEP))
                    begin
                        state_reg <= C_ROUND;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                C_ROUND:
                begin
                    angle_reg <= angle_next;
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sensor_angle_autocalibration.sv -----
// ----------------------------------------------------------------------------
// sensor_angle_autocalibration
// Self-calibrating X/Y sensor angle: min/max offset and amplitude tracking,
// fixed-point temperature offset correction and CORDIC atan2.
// ----------------------------------------------------------------------------
// Usage:
// A sample request carries an X/Y pair and is taken on a rising edge with
// sample_valid high and sample_stall low. Each one gives exactly one result
// request, in order: the angle in 1/2^ANGLE_FRACTION_BITS degree, its valid
// flag, and the offsets and amplitudes in use after this sample.
// An item passes from accept through the window check, the precalc of both
// axes on the shared multiplier and the CORDIC (normalization, pre-rotation,
// micro-rotations, rounding) to the output register; the CORDIC unit does one
// micro-rotation per cycle. With an amplitude of zero the precalc and CORDIC
// are skipped and the result follows the window check. sample_stall is high
// from accept until the result sits in the output register, so the next
// sample is taken only after that; it is taken while that result still
// waits under result_stall. Reset clears the min/max window to zero and
// empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sensor_angle_autocalibration
    import sac_pkg::*;
#(
    parameter int CORDIC_STEPS        = 24,
    parameter int ANGLE_FRACTION_BITS = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    typedef enum logic [2:0] {
        T_IDLE,
        T_CHECK,
        T_PRE,
        T_CORD,
        T_DONE
    } tstate_t;

    tstate_t            state_reg;
    sample_t            sample_reg;
    logic               angle_ok_reg;
    logic               result_valid_reg;
    result_t            result_reg;
    window_t            win;
    vec_t               vec;
    logic               accept, amp_ok, slot_free, load_result;
    logic               pre_start, pre_done, cordic_done;
    logic [ANGLE_W-1:0] angle;

    assign sample_stall = (state_reg != T_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign amp_ok       = (win.amp_x != '0) && (win.amp_y != '0);
    assign pre_start    = (state_reg == T_CHECK) && amp_ok;
    assign slot_free    = !result_valid_reg || !result_stall;
    assign load_result  = (state_reg == T_DONE) && slot_free;

    sac_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (accept),
        .sample (sample),
        .win    (win)
    );

    sac_precalc u_precalc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (pre_start),
        .sample (sample_reg),
        .win    (win),
        .done   (pre_done),
        .vec    (vec)
    );

    sac_cordic #(
        .CORDIC_STEPS        (CORDIC_STEPS),
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pre_done),
        .vec   (vec),
        .done  (cordic_done),
        .angle (angle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            sample_reg       <= '0;
            angle_ok_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        sample_reg <= sample;
                        state_reg  <= T_CHECK;
                    end
                end
                T_CHECK:
                begin
                    angle_ok_reg <= amp_ok;
                    state_reg    <= amp_ok ? T_PRE : T_DONE;
                end
                T_PRE:
                begin
                    if (pre_done)
                    begin
                        state_reg <= T_CORD;
                    end
                end
                T_CORD:
                begin
                    if (cordic_done)
                    begin
                        state_reg <= T_DONE;
                    end
                end
                T_DONE:
                begin
                    if (slot_free)
                    begin
                        result_reg.angle_deg       <= angle_ok_reg ? angle : '0;
                        result_reg.angle_valid     <= angle_ok_reg;
                        result_reg.offset_x_out    <= win.offset_x;
                        result_reg.offset_y_out    <= win.offset_y;
                        result_reg.amplitude_x_out <= win.amp_x;
                        result_reg.amplitude_y_out <= win.amp_y;
                        state_reg                  <= T_IDLE;
                    end
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_ALWAYS(a_valid_flag_amp, clk, rst_n,
        result_valid |-> (result.angle_valid == ((result.amplitude_x_out != '0)
            && (result.amplitude_y_out != '0))),
        "angle_valid disagrees with amplitudes")
    `ASSERT_ALWAYS(a_invalid_angle_zero, clk, rst_n,
        (result_valid && !result.angle_valid) |-> (result.angle_deg == '0),
        "invalid result carries a nonzero angle")
    `ASSERT_ALWAYS(a_pre_done_in_pre, clk, rst_n,
        pre_done |-> (state_reg == T_PRE),
        "precalc finished outside its phase")
    `ASSERT_NEXT(a_window_held, clk, rst_n,
        state_reg != T_IDLE, $stable(win),
        "calibration window moved while busy")

endmodule

`default_nettype wire
